// ===== rtl/srwf_pkg.sv =====
// Shared types, constants and codes for the soft rank window filter.
`timescale 1ns / 1ps
`default_nettype none
package srwf_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int MAX_HALF   = 7;
  localparam int PIXEL_BITS = 8;

  localparam int ROW_W  = 6;
  localparam int COL_W  = 6;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int EXT_W  = 7;
  localparam int HALF_W = 3;
  localparam int SPAN_W = 4;
  localparam int NOISE_W = 8;
  localparam int CFG_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int RANK_W = 16;
  localparam int NUM_W  = 17;
  localparam int FRAC_W = 8;
  localparam int DIV_BITS = NUM_W + FRAC_W;
  localparam int DVS_W  = NOISE_W + 1;
  localparam int DCNT_W = 5;
  localparam int CONTRIB_W = NOISE_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WINDOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_LEVEL  = 2'd3;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic                  action;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic [PIXEL_BITS-1:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CEN,
    ST_SWEEP,
    ST_DRAIN,
    ST_DIVS,
    ST_DIVW
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/srwf_mem.sv =====
// Frame store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module srwf_mem (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [srwf_pkg::ADDR_W-1:0]     waddr,
  input  wire logic [srwf_pkg::PIXEL_BITS-1:0] wdata,
  input  wire logic [srwf_pkg::ADDR_W-1:0]     raddr,
  output logic      [srwf_pkg::PIXEL_BITS-1:0] rdata
);
  import srwf_pkg::*;

  logic [PIXEL_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/srwf_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module srwf_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [srwf_pkg::DIV_BITS-1:0] dividend,
  input  wire logic [srwf_pkg::DVS_W-1:0]    divisor,
  output logic                               done,
  output logic      [srwf_pkg::RANK_W-1:0]   quotient
);
  import srwf_pkg::*;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DIV_BITS-1:0] dvd_r, dvd_nxt;
  logic [RANK_W-1:0]   quo_r, quo_nxt;
  logic [DVS_W-1:0]    rem_r, rem_nxt;
  logic [DVS_W-1:0]    dvs_r, dvs_nxt;
  logic [DVS_W:0]      trial;
  logic [DVS_W:0]      diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    trial    = {rem_r, dvd_r[DIV_BITS-1]};
    diff     = trial - {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DCNT_W'(DIV_BITS);
      dvd_nxt  = dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DIV_BITS-2:0], 1'b0};
      // the quotient never exceeds the rank width, so upper bits shift out as zero
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DVS_W-1:0];
        quo_nxt = {quo_r[RANK_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DVS_W-1:0];
        quo_nxt = {quo_r[RANK_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - DCNT_W'(1);
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ===== rtl/soft_rank_window_filter_unit.sv =====
// Top level of the soft rank window filter: control, window sweep and result register.
//
// Channels: an item is taken at a rising edge with start high and busy low.
// A load item (action 0) writes its pixel into the 64x64 frame store at that
// edge and leaves busy low, so another item may follow in the next cycle.
// A query item (action 1) gives one result on out_item, marked by a one-cycle
// out_strobe; a load gives none. Configuration (cfg_we, cfg_index, cfg_data)
// is taken at an edge with cfg_we high; the user must write it only while no
// query is in flight, which the block does not enforce. An error query shows
// its result in the cycle after acceptance and keeps busy low. Otherwise busy
// rises for a center read, the window reads (one per pixel) from the single
// frame store read port, a drain state and a dispatch state; with noise 0 the
// result follows then, else a bit-serial divide comes first. The store's read
// port sets the sweep length.
// Reset clears the control state and loads the register reset values; the
// frame store is not cleared and must be loaded before it is queried.
// Results cannot be held off: each is marked by out_strobe for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none
module soft_rank_window_filter_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire srwf_pkg::in_item_t             in_item,
  output logic                                out_strobe,
  output srwf_pkg::out_item_t                 out_item,
  input  wire logic                           cfg_we,
  input  wire logic [srwf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [srwf_pkg::CFG_W-1:0]     cfg_data
);
  import srwf_pkg::*;

  state_t state_r, state_nxt;

  logic [EXT_W-1:0]      fwidth_r, fheight_r;
  logic [HALF_W-1:0]     half_r;
  logic [NOISE_W-1:0]    noise_r;

  logic [ROW_W-1:0]      r0_r, r0_nxt;
  logic [COL_W-1:0]      c0_r, c0_nxt;
  logic [ADDR_W-1:0]     cen_addr_r, cen_addr_nxt;
  logic [SPAN_W-1:0]     span_r, span_nxt;
  logic [SPAN_W-1:0]     wr_r, wr_nxt, wc_r, wc_nxt;
  logic [PIXEL_BITS-1:0] cen_r, cen_nxt;
  logic [NUM_W-1:0]      num_r, num_nxt;
  logic                  rd_cen_r, rd_cen_nxt, rd_win_r, rd_win_nxt;
  logic                  out_strobe_r, out_strobe_nxt;
  out_item_t             out_item_r, out_item_nxt;
  logic                  div_start;

  logic                  accept;
  logic [EXT_W-1:0]      w_sat, h_sat;
  logic [HALF_W-1:0]     s_sat;
  logic [SPAN_W-1:0]     span_q;
  logic                  q_err;
  logic [EXT_W-1:0]      rc, cc;
  logic [ADDR_W-1:0]     raddr;
  logic [ROW_W-1:0]      win_row;
  logic [COL_W-1:0]      win_col;
  logic [PIXEL_BITS-1:0] rd_data;
  logic signed [NOISE_W+1:0] diff, nz;
  logic [CONTRIB_W-1:0]  contrib;
  logic                  div_done;
  logic [RANK_W-1:0]     div_quo;

  // Clamp a window center so the whole window stays inside the extent, and return the window's low edge.
  function automatic logic [EXT_W-1:0] clamp_lo(input logic [EXT_W-1:0] pos,
                                                input logic [HALF_W-1:0] half,
                                                input logic [EXT_W-1:0] ext);
    logic [EXT_W-1:0] c;
    logic [EXT_W-1:0] hi;
    c  = pos;
    hi = ext - EXT_W'(half) - EXT_W'(1);
    if (c < EXT_W'(half)) c = EXT_W'(half);
    if (c > hi) c = hi;
    return c - EXT_W'(half);
  endfunction

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    w_sat  = (fwidth_r > EXT_W'(MAX_WIDTH)) ? EXT_W'(MAX_WIDTH) : fwidth_r;
    h_sat  = (fheight_r > EXT_W'(MAX_HEIGHT)) ? EXT_W'(MAX_HEIGHT) : fheight_r;
    s_sat  = (half_r > HALF_W'(MAX_HALF)) ? HALF_W'(MAX_HALF) : half_r;
    span_q = {s_sat, 1'b1};
    q_err  = ({1'b0, in_item.row} >= h_sat) || ({1'b0, in_item.col} >= w_sat) ||
             (EXT_W'(span_q) > w_sat) || (EXT_W'(span_q) > h_sat);
    rc     = clamp_lo({1'b0, in_item.row}, s_sat, h_sat);
    cc     = clamp_lo({1'b0, in_item.col}, s_sat, w_sat);
  end

  always_comb begin
    win_row = r0_r + ROW_W'(wr_r);
    win_col = c0_r + COL_W'(wc_r);
    raddr   = (state_r == ST_CEN) ? cen_addr_r : {win_row, win_col};
  end

  // Contribution of one window pixel, scaled by twice the noise level; with noise 0 it is 1 for a darker pixel, else 0.
  always_comb begin
    diff = $signed({2'b00, rd_data}) - $signed({2'b00, cen_r});
    nz   = $signed({2'b00, noise_r});
    if (noise_r == '0) begin
      contrib = (diff < 0) ? CONTRIB_W'(1) : '0;
    end else if (diff <= -nz) begin
      contrib = {noise_r, 1'b0};
    end else if (diff < nz) begin
      contrib = CONTRIB_W'(nz - diff);
    end else begin
      contrib = '0;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    r0_nxt         = r0_r;
    c0_nxt         = c0_r;
    cen_addr_nxt   = cen_addr_r;
    span_nxt       = span_r;
    wr_nxt         = wr_r;
    wc_nxt         = wc_r;
    cen_nxt        = cen_r;
    num_nxt        = num_r;
    rd_cen_nxt     = 1'b0;
    rd_win_nxt     = 1'b0;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    div_start      = 1'b0;

    if (rd_cen_r) cen_nxt = rd_data;
    if (rd_win_r) num_nxt = num_r + NUM_W'(contrib);

    case (state_r)
      ST_IDLE: begin
        if (accept && in_item.action == ACT_QUERY) begin
          if (q_err) begin
            out_strobe_nxt     = 1'b1;
            out_item_nxt.rank  = '0;
            out_item_nxt.error = 1'b1;
          end else begin
            r0_nxt       = rc[ROW_W-1:0];
            c0_nxt       = cc[COL_W-1:0];
            cen_addr_nxt = {in_item.row, in_item.col};
            span_nxt     = span_q;
            state_nxt    = ST_CEN;
          end
        end
      end
      ST_CEN: begin
        rd_cen_nxt = 1'b1;
        wr_nxt     = '0;
        wc_nxt     = '0;
        num_nxt    = '0;
        state_nxt  = ST_SWEEP;
      end
      ST_SWEEP: begin
        rd_win_nxt = 1'b1;
        // advance column first, then row
        if (wc_r == span_r - SPAN_W'(1)) begin
          wc_nxt = '0;
          wr_nxt = wr_r + SPAN_W'(1);
          if (wr_r == span_r - SPAN_W'(1)) state_nxt = ST_DRAIN;
        end else begin
          wc_nxt = wc_r + SPAN_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DIVS;
      end
      ST_DIVS: begin
        if (noise_r == '0) begin
          out_strobe_nxt     = 1'b1;
          out_item_nxt.rank  = RANK_W'({num_r, {FRAC_W{1'b0}}});
          out_item_nxt.error = 1'b0;
          state_nxt          = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIVW;
        end
      end
      ST_DIVW: begin
        if (div_done) begin
          out_strobe_nxt     = 1'b1;
          out_item_nxt.rank  = div_quo;
          out_item_nxt.error = 1'b0;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_cen_r     <= 1'b0;
      rd_win_r     <= 1'b0;
      out_strobe_r <= 1'b0;
      fwidth_r     <= EXT_W'(64);
      fheight_r    <= EXT_W'(64);
      half_r       <= HALF_W'(1);
      noise_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      rd_cen_r     <= rd_cen_nxt;
      rd_win_r     <= rd_win_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  fwidth_r  <= cfg_data[EXT_W-1:0];
          REG_FRAME_HEIGHT: fheight_r <= cfg_data[EXT_W-1:0];
          REG_HALF_WINDOW:  half_r    <= cfg_data[HALF_W-1:0];
          REG_NOISE_LEVEL:  noise_r   <= cfg_data[NOISE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    r0_r       <= r0_nxt;
    c0_r       <= c0_nxt;
    cen_addr_r <= cen_addr_nxt;
    span_r     <= span_nxt;
    wr_r       <= wr_nxt;
    wc_r       <= wc_nxt;
    cen_r      <= cen_nxt;
    num_r      <= num_nxt;
    out_item_r <= out_item_nxt;
  end

  srwf_mem u_mem (
    .clk   (clk),
    .we    (accept && in_item.action == ACT_LOAD),
    .waddr ({in_item.row, in_item.col}),
    .wdata (in_item.pixel),
    .raddr (raddr),
    .rdata (rd_data)
  );

  srwf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({num_r, {FRAC_W{1'b0}}}),
    .divisor  ({noise_r, 1'b0}),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule
`default_nettype wire

// ===== tb/soft_rank_checker.sv =====
// Checker for the soft rank window filter: tracks items and config, predicts and compares ranks.
`timescale 1ns / 1ps
module soft_rank_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire srwf_pkg::in_item_t             in_item,
  input  wire logic                           out_strobe,
  input  wire srwf_pkg::out_item_t            out_item,
  input  wire logic                           cfg_we,
  input  wire logic [srwf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [srwf_pkg::CFG_W-1:0]     cfg_data,
  output int                                  mismatch_count,
  output int                                  ranks_owed
);
  import srwf_pkg::*;

  logic [PIXEL_BITS-1:0] frame_px [0:DEPTH-1];
  logic [EXT_W-1:0]      frame_w;
  logic [EXT_W-1:0]      frame_h;
  logic [HALF_W-1:0]     half_win;
  logic [NOISE_W-1:0]    noise;
  out_item_t             ranks_due [$];

  function automatic int clamp_centre(int pos, int half, int extent);
    int c;
    c = pos;
    if (c < half) c = half;
    if (c > extent - half - 1) c = extent - half - 1;
    return c;
  endfunction

  function automatic out_item_t predict_rank(logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    int        w, h, s, n, span, rc, cc, cen, d, r, k;
    longint    num;
    out_item_t res;
    w = (frame_w > MAX_WIDTH) ? MAX_WIDTH : int'(frame_w);
    h = (frame_h > MAX_HEIGHT) ? MAX_HEIGHT : int'(frame_h);
    s = (half_win > MAX_HALF) ? MAX_HALF : int'(half_win);
    n = int'(noise);
    span = 2 * s + 1;
    res.rank = '0;
    res.error = 1'b1;
    if (row >= h || col >= w || span > w || span > h) return res;
    rc = clamp_centre(int'(row), s, h);
    cc = clamp_centre(int'(col), s, w);
    cen = int'(frame_px[int'(row) * MAX_WIDTH + int'(col)]);
    num = 0;
    for (r = rc - s; r <= rc + s; r++) begin
      for (k = cc - s; k <= cc + s; k++) begin
        d = int'(frame_px[r * MAX_WIDTH + k]) - cen;
        if (n == 0) begin
          if (d < 0) num += 1;
        end else if (d <= -n) begin
          num += 2 * n;
        end else if (d < n) begin
          num += n - d;
        end
      end
    end
    // rank is the band-weighted count in 8.8 fixed point, truncated
    if (n == 0) res.rank = RANK_W'(num << FRAC_W);
    else res.rank = RANK_W'((num << FRAC_W) / (2 * n));
    res.error = 1'b0;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      frame_w = 7'd64;
      frame_h = 7'd64;
      half_win = 3'd1;
      noise = 8'd0;
      ranks_due.delete();
    end else begin
      if (out_strobe) begin
        if (ranks_due.size() == 0) begin
          report_mismatch("stray result rank", int'(out_item.rank), -1);
        end else begin
          want = ranks_due.pop_front();
          if (out_item.error !== want.error)
            report_mismatch("error flag", int'(out_item.error), int'(want.error));
          if (out_item.rank !== want.rank)
            report_mismatch("rank", int'(out_item.rank), int'(want.rank));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  frame_w = cfg_data[EXT_W-1:0];
          REG_FRAME_HEIGHT: frame_h = cfg_data[EXT_W-1:0];
          REG_HALF_WINDOW:  half_win = cfg_data[HALF_W-1:0];
          REG_NOISE_LEVEL:  noise = cfg_data[NOISE_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_item.action == ACT_LOAD)
          frame_px[int'(in_item.row) * MAX_WIDTH + int'(in_item.col)] = in_item.pixel;
        else
          ranks_due.push_back(predict_rank(in_item.row, in_item.col));
      end
    end
    ranks_owed = ranks_due.size();
  end

endmodule

// ===== tb/soft_rank_window_filter_unit_tb.sv =====
// Stimulus and verdict for the soft rank window filter unit.
`timescale 1ns / 1ps
module soft_rank_window_filter_unit_tb;
  import srwf_pkg::*;

  localparam int ITEM_TARGET = 850;
  localparam int PHASE_ITEMS = 60;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_item;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   mismatch_count;
  int                   ranks_owed;

  // what the stimulus knows of the block: its settings and which pixels hold data
  bit written [0:DEPTH-1];
  int cur_w, cur_h, cur_s, cur_n;
  int idle_pct;
  int pix_base, pix_spread;
  int sent;

  soft_rank_window_filter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  soft_rank_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_item        (in_item),
    .out_strobe     (out_strobe),
    .out_item       (out_item),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .ranks_owed     (ranks_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int sat(int v, int lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic bit window_reads(int r, int c);
    int w, h, span;
    w = sat(cur_w, MAX_WIDTH);
    h = sat(cur_h, MAX_HEIGHT);
    span = 2 * cur_s + 1;
    return (r < h && c < w && span <= w && span <= h);
  endfunction

  function automatic int window_lo(int pos, int extent);
    int c;
    c = pos;
    if (c < cur_s) c = cur_s;
    if (c > extent - cur_s - 1) c = extent - cur_s - 1;
    return c - cur_s;
  endfunction

  function automatic int unwritten_in_window(int r, int c);
    int r0, c0, i, j, cnt;
    cnt = 0;
    if (!window_reads(r, c)) return 0;
    r0 = window_lo(r, sat(cur_h, MAX_HEIGHT));
    c0 = window_lo(c, sat(cur_w, MAX_WIDTH));
    for (i = r0; i <= r0 + 2 * cur_s; i++)
      for (j = c0; j <= c0 + 2 * cur_s; j++)
        if (!written[i * MAX_WIDTH + j]) cnt++;
    return cnt;
  endfunction

  function automatic int next_pixel();
    int v;
    if ($urandom_range(99) < 15) return $urandom_range(255);
    v = pix_base + $urandom_range(pix_spread);
    return sat(v, 255);
  endfunction

  task automatic send(input logic act, input int r, input int c, input int px);
    int       gap;
    in_item_t it;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    it.action = act;
    it.row = r[ROW_W-1:0];
    it.col = c[COL_W-1:0];
    it.pixel = px[PIXEL_BITS-1:0];
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (act == ACT_LOAD) written[r * MAX_WIDTH + c] = 1'b1;
    sent++;
  endtask

  // fill whatever the window still lacks, then ask for the rank
  task automatic query(input int r, input int c);
    int r0, c0, i, j;
    if (window_reads(r, c)) begin
      r0 = window_lo(r, sat(cur_h, MAX_HEIGHT));
      c0 = window_lo(c, sat(cur_w, MAX_WIDTH));
      for (i = r0; i <= r0 + 2 * cur_s; i++)
        for (j = c0; j <= c0 + 2 * cur_s; j++)
          if (!written[i * MAX_WIDTH + j]) send(ACT_LOAD, i, j, next_pixel());
    end
    send(ACT_QUERY, r, c, $urandom_range(255));
  endtask

  // hold start low until every rank has come back and the block is idle
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (ranks_owed != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_config(input int w, input int h, input int s, input int n);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data <= {1'($urandom_range(1)), 7'(w)};
    @(negedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data <= {1'($urandom_range(1)), 7'(h)};
    @(negedge clk);
    cfg_index <= REG_HALF_WINDOW;
    cfg_data <= {5'($urandom_range(31)), 3'(s)};
    @(negedge clk);
    cfg_index <= REG_NOISE_LEVEL;
    cfg_data <= 8'(n);
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_w = w;
    cur_h = h;
    cur_s = s;
    cur_n = n;
  endtask

  task automatic plan_phase(input int ph, output int w, output int h, output int s,
                            output int n);
    case (ph)
      0: begin w = 64; h = 64; s = 0; n = 0; end
      1: begin w = 127; h = 100; s = 2; n = 255; end
      2: begin w = 15; h = 15; s = 7; n = 1; end
      3: begin w = 20; h = 64; s = 7; n = 16; end
      4: begin w = 0; h = 5; s = 1; n = 3; end
      5: begin w = 5; h = 0; s = 1; n = 3; end
      6: begin w = 1; h = 1; s = 0; n = 128; end
      7: begin w = 64; h = 1; s = 0; n = 8; end
      8: begin w = 1; h = 64; s = 0; n = 0; end
      9: begin w = 9; h = 40; s = 4; n = 0; end
      default: begin
        w = ($urandom_range(9) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 40);
        h = ($urandom_range(9) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 40);
        s = ($urandom_range(9) < 6) ? $urandom_range(0, 3) : $urandom_range(0, 7);
        case ($urandom_range(3))
          0: n = 0;
          1: n = $urandom_range(1, 8);
          2: n = $urandom_range(9, 254);
          default: n = 255;
        endcase
      end
    endcase
  endtask

  task automatic pick_target(output int r, output int c);
    int  tries;
    bit  found;
    tries = 0;
    found = 1'b0;
    while (!found && tries < 6) begin
      if ($urandom_range(9) == 0) begin
        r = $urandom_range(63);
        c = $urandom_range(63);
      end else begin
        r = sat($urandom_range(0, sat(cur_h, MAX_HEIGHT)), 63);
        c = sat($urandom_range(0, sat(cur_w, MAX_WIDTH)), 63);
      end
      // steer away from windows that would need a long fill
      found = (unwritten_in_window(r, c) <= 40);
      tries++;
    end
  endtask

  initial begin : stimulus
    int ph, w, h, s, n, r, c, phase_end;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    cur_w = 64;
    cur_h = 64;
    cur_s = 1;
    cur_n = 0;
    idle_pct = 0;
    pix_base = 0;
    pix_spread = 255;
    sent = 0;
    for (int i = 0; i < DEPTH; i++) written[i] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: band edges around a centre of 128, extreme values and corners
    send(ACT_LOAD, 0, 0, 128);
    send(ACT_LOAD, 0, 1, 0);
    send(ACT_LOAD, 0, 2, 255);
    send(ACT_LOAD, 1, 0, 127);
    send(ACT_LOAD, 1, 1, 128);
    send(ACT_LOAD, 1, 2, 129);
    send(ACT_LOAD, 2, 0, 0);
    send(ACT_LOAD, 2, 1, 255);
    send(ACT_LOAD, 2, 2, 1);
    send(ACT_LOAD, 63, 63, 255);
    // reset settings: 64x64, 3x3 window, hard rank
    send(ACT_QUERY, 0, 0, 0);
    send(ACT_QUERY, 1, 1, 255);
    send(ACT_QUERY, 0, 1, 0);
    set_config(3, 3, 1, 128);
    send(ACT_QUERY, 0, 0, 0);
    send(ACT_QUERY, 2, 2, 0);
    send(ACT_QUERY, 1, 1, 0);
    send(ACT_QUERY, 3, 0, 0);
    send(ACT_QUERY, 0, 3, 0);
    set_config(3, 3, 2, 128);
    send(ACT_QUERY, 1, 1, 0);
    set_config(0, 3, 1, 0);
    send(ACT_QUERY, 0, 0, 0);
    set_config(3, 0, 1, 0);
    send(ACT_QUERY, 0, 0, 0);

    ph = 0;
    while (sent < ITEM_TARGET) begin
      plan_phase(ph, w, h, s, n);
      set_config(w, h, s, n);
      case (ph % 4)
        1: idle_pct = 46;
        3: idle_pct = 35;
        default: idle_pct = 0;
      endcase
      pix_base = $urandom_range(255);
      pix_spread = (n == 0) ? $urandom_range(16) : sat($urandom_range(3 * n), 255);
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        if ($urandom_range(99) < 3) settle();
        if ($urandom_range(99) < 35) begin
          if ($urandom_range(3) == 0) begin
            r = $urandom_range(63);
            c = $urandom_range(63);
          end else begin
            r = sat($urandom_range(0, sat(h, MAX_HEIGHT)), 63);
            c = sat($urandom_range(0, sat(w, MAX_WIDTH)), 63);
          end
          send(ACT_LOAD, r, c, next_pixel());
        end else begin
          pick_target(r, c);
          query(r, c);
        end
      end
      ph++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (ranks_owed != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
